>>> rtl/drfp_pkg.sv
// Shared types and constants for the delimited record field parser.
// Used by the front, queue, back and top modules; no dependencies.
package drfp_pkg;

  localparam int MAX_LEN_DEF     = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int LIMIT_W = 6;
  localparam logic [LIMIT_W-1:0] BUF_LIMIT_RST = 6'd32;

  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [2:0] FK_DATE  = 3'd0;
  localparam logic [2:0] FK_TIME  = 3'd1;
  localparam logic [2:0] FK_KEY   = 3'd2;
  localparam logic [2:0] FK_ACCT  = 3'd3;
  localparam logic [2:0] FK_ALARM = 3'd4;

  localparam int SEG_POS_W = 4;
  localparam int SEG_CNT_W = 4;

  typedef enum logic [2:0] {
    PH_ID, PH_DATE, PH_TIME, PH_BANK, PH_ACCT, PH_KEY, PH_CARD, PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    KIND_NONE, KIND_L, KIND_E
  } kind_e;

  typedef enum logic {
    OP_WRITE, OP_EMIT
  } cmd_op_e;

  typedef enum logic [1:0] {
    BK_IDLE, BK_SEG, BK_LOAD
  } back_state_e;

  typedef enum logic [1:0] {
    STG_A, STG_B, STG_ALARM
  } stage_e;

  typedef struct packed {
    logic [2:0]           kind;
    logic [SEG_POS_W-1:0] start;
    logic [SEG_CNT_W-1:0] cnt;
  } seg_t;

  typedef struct packed {
    cmd_op_e    op;
    logic [7:0] data;
    seg_t       seg_a;
    seg_t       seg_b;
    logic       alarm;
    logic       rtype;
  } cmd_t;

endpackage

>>> rtl/drfp_front.sv
// Front end: accepts bytes, tracks token length, phase and record kind,
// and turns accepted bytes into store writes or emit requests. Uses drfp_pkg.
module drfp_front #(
  parameter int MAX_LEN = drfp_pkg::MAX_LEN_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     data_byte_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [drfp_pkg::LIMIT_W-1:0]   cfg_data_i,
  output logic                           push_o,
  output drfp_pkg::cmd_t                 push_cmd_o,
  output logic [$clog2(MAX_LEN)-1:0]     push_addr_o,
  input  logic                           q_full_i
);
  import drfp_pkg::*;

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = (LW > LIMIT_W) ? LW : LIMIT_W;

  logic [LIMIT_W-1:0] limit_q;
  logic [LW-1:0]      len_q, len_d, len0;
  phase_e             phase_q, phase_d, ph0, nph;
  kind_e              kind_q, kind_d, nkind;
  logic [7:0]         first_q, first_d, stored;
  logic               accept, is_delim, lim_hit, clr, done;
  seg_t               seg_a, seg_b;

  function automatic seg_t mk_seg(logic [2:0] k, logic [SEG_POS_W-1:0] s,
                                  logic [SEG_CNT_W-1:0] c);
    seg_t r;
    r.kind  = k;
    r.start = s;
    r.cnt   = c;
    return r;
  endfunction

  function automatic phase_e adv(phase_e p, kind_e k);
    phase_e r;
    r = PH_ID;
    unique case (p)
      PH_ID:   r = PH_DATE;
      PH_DATE: r = PH_TIME;
      PH_TIME: begin
        if (k == KIND_L)      r = PH_BANK;
        else if (k == KIND_E) r = PH_KEY;
        else                  r = PH_ID;
      end
      PH_BANK: r = PH_ACCT;
      PH_ACCT: r = PH_DONE;
      PH_KEY:  r = PH_CARD;
      PH_CARD: r = PH_DONE;
      default: r = PH_ID;
    endcase
    return r;
  endfunction

  assign in_stall_o  = q_full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !q_full_i;
  assign is_delim    = (data_byte_i == CH_SPACE) || (data_byte_i == CH_CR);
  assign stored      = (data_byte_i != 8'h00) ? data_byte_i : CH_SPACE;
  assign lim_hit     = (CW'(len_q) >= CW'(limit_q)) || (len_q >= LW'(MAX_LEN));
  assign len0        = lim_hit ? '0 : len_q;
  assign ph0         = lim_hit ? PH_ID : phase_q;

  always_comb begin
    len_d       = len_q;
    phase_d     = phase_q;
    kind_d      = kind_q;
    first_d     = first_q;
    push_o      = 1'b0;
    push_cmd_o  = '0;
    push_addr_o = len0[AW-1:0];
    nkind       = kind_q;
    nph         = ph0;
    clr         = 1'b1;
    done        = 1'b0;
    seg_a       = '0;
    seg_b       = '0;
    if (accept) begin
      if (!is_delim) begin
        len_d   = len0;
        phase_d = ph0;
        if (len0 < LW'(MAX_LEN)) begin
          push_o          = 1'b1;
          push_cmd_o.op   = OP_WRITE;
          push_cmd_o.data = stored;
          len_d           = len0 + LW'(1);
          if (len0 == '0) first_d = stored;
        end
      end else begin
        unique case (ph0)
          PH_ID: begin
            nkind = KIND_NONE;
            if (len0 != '0 && first_q == CH_L)      nkind = KIND_L;
            else if (len0 != '0 && first_q == CH_E) nkind = KIND_E;
            if (nkind == KIND_NONE) begin
              clr = 1'b0;
            end else if (len0 == LW'(1)) begin
              nph = PH_DATE;
            end else if (len0 == LW'(9) || len0 == LW'(10)) begin
              seg_a = mk_seg(FK_DATE, SEG_POS_W'(len0 - LW'(8)), SEG_CNT_W'(8));
              nph   = PH_TIME;
            end else begin
              done = 1'b1;
            end
          end
          PH_DATE: begin
            if (len0 == LW'(8)) begin
              seg_a = mk_seg(FK_DATE, '0, SEG_CNT_W'(8));
              nph   = PH_TIME;
            end else if (len0 == LW'(16) || len0 == LW'(17)) begin
              seg_a = mk_seg(FK_DATE, '0, SEG_CNT_W'(8));
              seg_b = mk_seg(FK_TIME, SEG_POS_W'(len0 - LW'(8)), SEG_CNT_W'(8));
              nph   = adv(PH_TIME, nkind);
            end else begin
              done = 1'b1;
            end
          end
          PH_TIME: begin
            if (len0 == LW'(8)) begin
              seg_a = mk_seg(FK_TIME, '0, SEG_CNT_W'(8));
              nph   = adv(PH_TIME, nkind);
            end else if (len0 == LW'(12) || len0 == LW'(13)) begin
              seg_a = mk_seg(FK_TIME, '0, SEG_CNT_W'(8));
              seg_b = mk_seg(FK_KEY, SEG_POS_W'(len0 - LW'(4)), SEG_CNT_W'(4));
              nph   = adv(adv(PH_TIME, nkind), nkind);
            end else if (len0 == LW'(16) || len0 == LW'(17)) begin
              seg_a = mk_seg(FK_TIME, '0, SEG_CNT_W'(8));
              seg_b = mk_seg(FK_KEY, SEG_POS_W'(len0 - LW'(8)), SEG_CNT_W'(8));
              nph   = adv(adv(PH_TIME, nkind), nkind);
            end else begin
              done = 1'b1;
            end
          end
          PH_BANK: begin
            if (len0 == LW'(8)) begin
              seg_a = mk_seg(FK_KEY, '0, SEG_CNT_W'(8));
              nph   = PH_ACCT;
            end else if (len0 == LW'(18) || len0 == LW'(19)) begin
              seg_a = mk_seg(FK_KEY, '0, SEG_CNT_W'(8));
              seg_b = mk_seg(FK_ACCT, SEG_POS_W'(len0 - LW'(10)), SEG_CNT_W'(10));
              done  = 1'b1;
            end else begin
              done = 1'b1;
            end
          end
          PH_ACCT: begin
            if (len0 == LW'(10)) seg_a = mk_seg(FK_ACCT, '0, SEG_CNT_W'(10));
            done = 1'b1;
          end
          PH_KEY: begin
            if (len0 == LW'(4)) begin
              seg_a = mk_seg(FK_KEY, '0, SEG_CNT_W'(4));
              nph   = PH_CARD;
            end else begin
              seg_a = mk_seg(FK_KEY, '0,
                             (len0 < LW'(4)) ? SEG_CNT_W'(len0) : SEG_CNT_W'(4));
              done  = 1'b1;
            end
          end
          PH_CARD: begin
            if (len0 <= LW'(14)) seg_a = mk_seg(FK_ACCT, '0, SEG_CNT_W'(len0));
            done = 1'b1;
          end
          default: ;
        endcase
        if (nph == PH_DONE) done = 1'b1;
        push_cmd_o.op    = OP_EMIT;
        push_cmd_o.seg_a = seg_a;
        push_cmd_o.seg_b = seg_b;
        push_cmd_o.alarm = done;
        push_cmd_o.rtype = (nkind == KIND_E);
        push_o = (seg_a.cnt != '0) || (seg_b.cnt != '0) || done;
        if (done) begin
          len_d   = '0;
          kind_d  = KIND_NONE;
          phase_d = PH_ID;
        end else begin
          len_d   = clr ? '0 : len0;
          kind_d  = nkind;
          phase_d = nph;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= BUF_LIMIT_RST;
      len_q   <= '0;
      phase_q <= PH_ID;
      kind_q  <= KIND_NONE;
    end else begin
      if (cfg_valid_i && cfg_ready_o) limit_q <= cfg_data_i;
      len_q   <= len_d;
      phase_q <= phase_d;
      kind_q  <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
  end

  a_kind_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kind_q == KIND_NONE |-> phase_q == PH_ID)
    else $error("front: record kind unknown outside identifier phase");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(MAX_LEN) && phase_q != PH_DONE)
    else $error("front: token length or phase out of range");

endmodule

>>> rtl/drfp_queue.sv
// Request queue between front and back ends.
// Holds write and emit requests in order. Uses drfp_pkg.
module drfp_queue #(
  parameter int DEPTH   = drfp_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_LEN = drfp_pkg::MAX_LEN_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  drfp_pkg::cmd_t             push_cmd_i,
  input  logic [$clog2(MAX_LEN)-1:0] push_addr_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic                       empty_o,
  output drfp_pkg::cmd_t             head_cmd_o,
  output logic [$clog2(MAX_LEN)-1:0] head_addr_o
);
  import drfp_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  cmd_t          cmd_q  [DEPTH];
  logic [AW-1:0] addr_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [NW-1:0] cnt_q;

  assign full_o      = (cnt_q == NW'(DEPTH));
  assign empty_o     = (cnt_q == '0);
  assign head_cmd_o  = cmd_q[rd_ptr_q];
  assign head_addr_o = addr_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + NW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      cmd_q[wr_ptr_q]  <= push_cmd_i;
      addr_q[wr_ptr_q] <= push_addr_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue: request pushed while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("queue: request popped while empty");

endmodule

>>> rtl/drfp_back.sv
// Back end: owns the token store, runs writes and emits field characters
// into the output register. Uses drfp_pkg.
module drfp_back #(
  parameter int MAX_LEN = drfp_pkg::MAX_LEN_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_empty_i,
  input  drfp_pkg::cmd_t             q_cmd_i,
  input  logic [$clog2(MAX_LEN)-1:0] q_addr_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [2:0]                 field_kind_o,
  output logic [7:0]                 char_value_o,
  output logic                       end_of_field_o,
  output logic                       record_type_o,
  output logic                       last_o
);
  import drfp_pkg::*;

  localparam int AW = $clog2(MAX_LEN);

  logic [7:0]           mem_q [MAX_LEN];
  back_state_e          state_q, state_d;
  stage_e               stage_q, stage_d;
  logic [SEG_CNT_W-1:0] idx_q, idx_d;
  cmd_t                 job_q;
  seg_t                 cur;
  logic [7:0]           rd_data_q;
  logic [AW-1:0]        rd_addr;
  logic                 mem_we, rd_en, job_load, load, load_alarm;
  logic                 out_free, idx_last, res_last;
  logic                 out_valid_q;

  assign out_free = !out_valid_q || !out_stall_i;
  assign cur      = (stage_q == STG_A) ? job_q.seg_a : job_q.seg_b;
  assign idx_last = (idx_q + SEG_CNT_W'(1)) == cur.cnt;
  assign res_last = idx_last && !job_q.alarm &&
                    (stage_q == STG_B || job_q.seg_b.cnt == '0);
  assign rd_addr  = AW'(cur.start) + AW'(idx_q);

  always_comb begin
    state_d    = state_q;
    stage_d    = stage_q;
    idx_d      = idx_q;
    q_pop_o    = 1'b0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    job_load   = 1'b0;
    load       = 1'b0;
    load_alarm = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (q_cmd_i.op == OP_WRITE) begin
            mem_we = 1'b1;
          end else begin
            job_load = 1'b1;
            stage_d  = STG_A;
            idx_d    = '0;
            state_d  = BK_SEG;
          end
        end
      end
      BK_SEG: begin
        if (stage_q == STG_ALARM) begin
          if (!job_q.alarm) begin
            state_d = BK_IDLE;
          end else if (out_free) begin
            load_alarm = 1'b1;
            state_d    = BK_IDLE;
          end
        end else if (idx_q < cur.cnt) begin
          rd_en   = 1'b1;
          state_d = BK_LOAD;
        end else begin
          idx_d   = '0;
          stage_d = (stage_q == STG_A) ? STG_B : STG_ALARM;
        end
      end
      BK_LOAD: begin
        if (out_free) begin
          load    = 1'b1;
          idx_d   = idx_q + SEG_CNT_W'(1);
          state_d = BK_SEG;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load || load_alarm) out_valid_q <= 1'b1;
      else if (!out_stall_i)  out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
    idx_q   <= idx_d;
    if (job_load) job_q <= q_cmd_i;
    if (mem_we) mem_q[q_addr_i] <= q_cmd_i.data;
    if (rd_en) rd_data_q <= mem_q[rd_addr];
    if (load) begin
      field_kind_o   <= cur.kind;
      char_value_o   <= rd_data_q;
      end_of_field_o <= idx_last;
      record_type_o  <= job_q.rtype;
      last_o         <= res_last;
    end else if (load_alarm) begin
      field_kind_o   <= FK_ALARM;
      char_value_o   <= 8'h00;
      end_of_field_o <= 1'b0;
      record_type_o  <= job_q.rtype;
      last_o         <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  a_alarm_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && field_kind_o == FK_ALARM |-> last_o && !end_of_field_o &&
    char_value_o == 8'h00)
    else $error("back: malformed alarm result");

endmodule

>>> rtl/delimited_record_field_parser.sv
// Delimited record field parser: per-byte tokenizer and record field emitter.
// A plain byte becomes a store write queued from the front to the back; each of a
// delimiter's character results is read from the token store and then loaded into
// the output register, up to 19 results. Input stalls only while the request queue is full.
// Reset clears phase, record kind, token length, queue and output valid, and
// sets buffer_limit to 32; the token store is not cleared (no clearing pass).
module delimited_record_field_parser #(
  parameter int MAX_LEN     = drfp_pkg::MAX_LEN_DEF,
  parameter int QUEUE_DEPTH = drfp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   data_byte_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [drfp_pkg::LIMIT_W-1:0] cfg_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   field_kind_o,
  output logic [7:0]                   char_value_o,
  output logic                         end_of_field_o,
  output logic                         record_type_o,
  output logic                         last_o
);
  import drfp_pkg::*;

  localparam int AW = $clog2(MAX_LEN);

  logic          push, q_full, q_empty, q_pop;
  cmd_t          push_cmd, head_cmd;
  logic [AW-1:0] push_addr, head_addr;

  drfp_front #(
    .MAX_LEN(MAX_LEN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .push_cmd_o  (push_cmd),
    .push_addr_o (push_addr),
    .q_full_i    (q_full)
  );

  drfp_queue #(
    .DEPTH  (QUEUE_DEPTH),
    .MAX_LEN(MAX_LEN)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_cmd_i  (push_cmd),
    .push_addr_i (push_addr),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_cmd_o  (head_cmd),
    .head_addr_o (head_addr)
  );

  drfp_back #(
    .MAX_LEN(MAX_LEN)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_cmd_i        (head_cmd),
    .q_addr_i       (head_addr),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .field_kind_o   (field_kind_o),
    .char_value_o   (char_value_o),
    .end_of_field_o (end_of_field_o),
    .record_type_o  (record_type_o),
    .last_o         (last_o)
  );

endmodule
